FILE: src/mfq_pkg.sv
`timescale 1ns / 1ps
// Package of the multilevel feedback scheduler: beat types, register and outcome codes.
// Depends on nothing; every other file of the block uses it.
package mfq_pkg;

    localparam int LEVELS_DEF   = 4;
    localparam int CAPACITY_DEF = 16;
    localparam int BUDGET_REGS  = 4;
    localparam int ADDR_W       = 5;

    localparam logic [7:0]  QUANTUM_RST = 8'd10;
    localparam logic [23:0] BUDGET_RST0 = 24'd17;
    localparam logic [23:0] BUDGET_RST1 = 24'd300;
    localparam logic [23:0] BUDGET_RST2 = 24'd5196;
    localparam logic [23:0] BUDGET_RST3 = 24'd90000;

    localparam logic [2:0] REG_QUANTUM = 3'd0;
    localparam logic [2:0] REG_BUDGET0 = 3'd1;
    localparam logic [2:0] REG_BUDGET1 = 3'd2;
    localparam logic [2:0] REG_BUDGET2 = 3'd3;
    localparam logic [2:0] REG_BUDGET3 = 3'd4;

    typedef enum logic [2:0] {
        OC_ADDED    = 3'd0,
        OC_DROPPED  = 3'd1,
        OC_IDLE     = 3'd2,
        OC_REQUEUED = 3'd3,
        OC_DEMOTED  = 3'd4,
        OC_FINISHED = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic        action;
        logic [15:0] proc_id;
        logic [7:0]  run_time;
        logic [6:0]  job_priority;
    } in_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [1:0]  served_level;
        logic [15:0] served_id;
        logic [7:0]  remaining_time;
    } out_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  run_time;
        logic [6:0]  prio;
    } job_t;

    typedef struct packed {
        logic [7:0]                        quantum;
        logic [BUDGET_REGS-1:0][23:0]      budget;
    } cfg_t;

    function automatic logic [23:0] budget_rst(input int idx);
        logic [23:0] val;
        case (idx)
            0:       val = BUDGET_RST0;
            1:       val = BUDGET_RST1;
            2:       val = BUDGET_RST2;
            default: val = BUDGET_RST3;
        endcase
        return val;
    endfunction

endpackage

FILE: src/mfq_cell.sv
`timescale 1ns / 1ps
// One job slot of a level row; holds a job and passes the best-so-far and last job onward.
// Depends on mfq_pkg.
module mfq_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4,
    parameter int OCC_W    = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [OCC_W-1:0]     occ,
    input  logic                 wr_en,
    input  mfq_pkg::job_t        wr_job,
    input  logic                 prev_ok,
    input  mfq_pkg::job_t        prev_best,
    input  logic [IDX_W-1:0]     prev_idx,
    input  mfq_pkg::job_t        prev_last,
    output logic                 nxt_ok,
    output mfq_pkg::job_t        nxt_best,
    output logic [IDX_W-1:0]     nxt_idx,
    output mfq_pkg::job_t        nxt_last
);

    mfq_pkg::job_t    job_reg;
    logic             ok_reg;
    mfq_pkg::job_t    best_reg;
    logic [IDX_W-1:0] idx_reg;
    mfq_pkg::job_t    last_reg;
    logic             live;
    logic             take;
    logic             is_last;

    assign live    = OCC_W'(CELL_IDX) < occ;
    assign is_last = OCC_W'(CELL_IDX + 1) == occ;
    assign take    = live && (!prev_ok || (job_reg.prio < prev_best.prio) ||
                     ((job_reg.prio == prev_best.prio) && (job_reg.id < prev_best.id)));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            job_reg <= wr_job;
        end
        best_reg <= take ? job_reg : prev_best;
        idx_reg  <= take ? IDX_W'(CELL_IDX) : prev_idx;
        last_reg <= is_last ? job_reg : prev_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= prev_ok || take;
        end
    end

    assign nxt_ok   = ok_reg;
    assign nxt_best = best_reg;
    assign nxt_idx  = idx_reg;
    assign nxt_last = last_reg;

endmodule

FILE: src/mfq_cfg.sv
`timescale 1ns / 1ps
// Configuration registers of the scheduler behind an APB-style port.
// Depends on mfq_pkg.
module mfq_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output mfq_pkg::cfg_t               cfg
);

    mfq_pkg::cfg_t cfg_reg;
    mfq_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                mfq_pkg::REG_QUANTUM: cfg_next.quantum   = pwdata[7:0];
                mfq_pkg::REG_BUDGET0: cfg_next.budget[0] = pwdata[23:0];
                mfq_pkg::REG_BUDGET1: cfg_next.budget[1] = pwdata[23:0];
                mfq_pkg::REG_BUDGET2: cfg_next.budget[2] = pwdata[23:0];
                mfq_pkg::REG_BUDGET3: cfg_next.budget[3] = pwdata[23:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            mfq_pkg::REG_QUANTUM: prdata = {24'd0, cfg_reg.quantum};
            mfq_pkg::REG_BUDGET0: prdata = {8'd0, cfg_reg.budget[0]};
            mfq_pkg::REG_BUDGET1: prdata = {8'd0, cfg_reg.budget[1]};
            mfq_pkg::REG_BUDGET2: prdata = {8'd0, cfg_reg.budget[2]};
            mfq_pkg::REG_BUDGET3: prdata = {8'd0, cfg_reg.budget[3]};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quantum   <= mfq_pkg::QUANTUM_RST;
            cfg_reg.budget[0] <= mfq_pkg::BUDGET_RST0;
            cfg_reg.budget[1] <= mfq_pkg::BUDGET_RST1;
            cfg_reg.budget[2] <= mfq_pkg::BUDGET_RST2;
            cfg_reg.budget[3] <= mfq_pkg::BUDGET_RST3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/multilevel_feedback_scheduler_unit.sv
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler: one row of job cells per level and a controller.
// Depends on mfq_pkg, mfq_cell and mfq_cfg.
//
// Usage. The job channel (job_valid, job_stall, job) carries one beat per command:
// action 0 adds a job to level one, action 1 runs one scheduling tick. Every command
// gives exactly one beat on the result channel (res_valid, res_stall, res).
// The user writes registers through the APB-style port only while the block is idle;
// the block itself does not enforce this. An add or an idle tick has its result
// registered in DECIDE once the output register is free. A tick that serves a job
// walks the best-job search through the row of LEVEL_CAPACITY cells of its level,
// one cell per cycle, and registers its result in COMMIT. One command is in work at a
// time, so a new beat is accepted in the cycle after the previous result is loaded.
// A waiting result does not block acceptance of the next command; that command's
// result is held back while the receiver stalls.
// Reset empties all levels, restores register defaults and reloads all budgets.
// Job slots hold no reset value; only written slots are ever read.
module multilevel_feedback_scheduler_unit #(
    parameter int LEVELS         = mfq_pkg::LEVELS_DEF,
    parameter int LEVEL_CAPACITY = mfq_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    output logic                        job_stall,
    input  mfq_pkg::in_t                job,
    output logic                        res_valid,
    input  logic                        res_stall,
    output mfq_pkg::out_t               res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int LVL_W = $clog2(LEVELS);
    localparam int IDX_W = (LEVEL_CAPACITY > 1) ? $clog2(LEVEL_CAPACITY) : 1;
    localparam int OCC_W = $clog2(LEVEL_CAPACITY + 1);
    localparam int CNT_W = IDX_W;

    mfq_pkg::cfg_t     cfg;
    mfq_pkg::state_t   state_reg, state_next;
    mfq_pkg::in_t      item_reg;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OCC_W-1:0]  occ_reg [LEVELS];
    logic [OCC_W-1:0]  occ_next [LEVELS];
    logic signed [24:0] budget_reg [LEVELS];
    logic signed [24:0] budget_next [LEVELS];
    logic [LVL_W-1:0]  next_level_reg, next_level_next;
    logic              res_valid_reg, res_valid_next;
    mfq_pkg::out_t     res_reg, res_next;

    logic              found;
    logic [LVL_W-1:0]  found_lvl;
    logic              out_free;
    logic              emit;

    logic              wr1_en;
    logic [IDX_W-1:0]  wr1_idx;
    logic              wr2_en;
    logic [LVL_W-1:0]  wr2_lvl;
    logic [OCC_W-1:0]  wr2_idx;
    mfq_pkg::job_t     wr2_job;

    logic              ch_ok   [LEVELS][LEVEL_CAPACITY+1];
    mfq_pkg::job_t     ch_best [LEVELS][LEVEL_CAPACITY+1];
    logic [IDX_W-1:0]  ch_idx  [LEVELS][LEVEL_CAPACITY+1];
    mfq_pkg::job_t     ch_last [LEVELS][LEVEL_CAPACITY+1];

    mfq_pkg::job_t     sel_best;
    mfq_pkg::job_t     sel_last;
    logic [IDX_W-1:0]  sel_idx;
    logic [LVL_W-1:0]  dest;
    logic              push;
    logic              finished;
    logic [8:0]        new_time;
    logic [7:0]        rem;
    logic signed [24:0] charged;
    logic signed [24:0] reload;
    logic [2:0]        commit_code;

    mfq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        assign ch_ok[l][0]   = 1'b0;
        assign ch_best[l][0] = '0;
        assign ch_idx[l][0]  = '0;
        assign ch_last[l][0] = '0;
        for (genvar k = 0; k < LEVEL_CAPACITY; k++)
        begin : g_cell
            logic          hit1;
            logic          hit2;
            mfq_pkg::job_t wdata;

            assign hit1  = wr1_en && (lvl_reg == LVL_W'(l)) && (wr1_idx == IDX_W'(k));
            assign hit2  = wr2_en && (wr2_lvl == LVL_W'(l)) && (wr2_idx == OCC_W'(k));
            assign wdata = hit2 ? wr2_job : sel_last;

            mfq_cell #(
                .CELL_IDX (k),
                .IDX_W    (IDX_W),
                .OCC_W    (OCC_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .occ       (occ_reg[l]),
                .wr_en     (hit1 || hit2),
                .wr_job    (wdata),
                .prev_ok   (ch_ok[l][k]),
                .prev_best (ch_best[l][k]),
                .prev_idx  (ch_idx[l][k]),
                .prev_last (ch_last[l][k]),
                .nxt_ok    (ch_ok[l][k+1]),
                .nxt_best  (ch_best[l][k+1]),
                .nxt_idx   (ch_idx[l][k+1]),
                .nxt_last  (ch_last[l][k+1])
            );
        end
    end

    assign out_free  = !res_valid_reg || !res_stall;
    assign job_stall = state_reg != mfq_pkg::ST_IDLE;

    always_comb
    begin
        logic [LVL_W:0] cand;
        found     = 1'b0;
        found_lvl = '0;
        cand      = '0;
        for (int k = LEVELS - 1; k >= 0; k--)
        begin
            cand = {1'b0, next_level_reg} + (LVL_W + 1)'(k);
            if (cand >= (LVL_W + 1)'(LEVELS))
            begin
                cand = cand - (LVL_W + 1)'(LEVELS);
            end
            if (occ_reg[cand[LVL_W-1:0]] != '0)
            begin
                found     = 1'b1;
                found_lvl = cand[LVL_W-1:0];
            end
        end
    end

    always_comb
    begin
        sel_best = ch_best[lvl_reg][LEVEL_CAPACITY];
        sel_last = ch_last[lvl_reg][LEVEL_CAPACITY];
        sel_idx  = ch_idx[lvl_reg][LEVEL_CAPACITY];
        new_time = {1'b0, sel_best.run_time} - {1'b0, cfg.quantum};
        rem      = (new_time[8] || (new_time == 9'd0)) ? 8'd0 : new_time[7:0];
        finished = rem == 8'd0;
        charged  = budget_reg[lvl_reg] - $signed({17'd0, cfg.quantum});
        if (int'(lvl_reg) < mfq_pkg::BUDGET_REGS)
        begin
            reload = $signed({1'b0, cfg.budget[2'(lvl_reg)]});
        end
        else
        begin
            reload = $signed({1'b0, cfg.budget[mfq_pkg::BUDGET_REGS-1]});
        end
        dest        = lvl_reg;
        push        = !finished;
        commit_code = mfq_pkg::OC_REQUEUED;
        if (finished)
        begin
            commit_code = mfq_pkg::OC_FINISHED;
        end
        else if (charged < 0)
        begin
            commit_code = mfq_pkg::OC_DEMOTED;
            if (lvl_reg != LVL_W'(LEVELS - 1))
            begin
                if (occ_reg[lvl_reg + LVL_W'(1)] >= OCC_W'(LEVEL_CAPACITY))
                begin
                    commit_code = mfq_pkg::OC_REQUEUED;
                end
                else
                begin
                    dest = lvl_reg + LVL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfq_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = mfq_pkg::ST_DECIDE;
                end
            end
            mfq_pkg::ST_DECIDE:
            begin
                if (item_reg.action && found)
                begin
                    state_next = mfq_pkg::ST_SCAN;
                end
                else if (out_free)
                begin
                    state_next = mfq_pkg::ST_IDLE;
                end
            end
            mfq_pkg::ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(LEVEL_CAPACITY - 1))
                begin
                    state_next = mfq_pkg::ST_COMMIT;
                end
            end
            mfq_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = mfq_pkg::ST_IDLE;
                end
            end
            default: state_next = mfq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        emit            = 1'b0;
        res_next        = res_reg;
        lvl_next        = lvl_reg;
        cnt_next        = cnt_reg;
        next_level_next = next_level_reg;
        wr1_en          = 1'b0;
        wr1_idx         = sel_idx;
        wr2_en          = 1'b0;
        wr2_lvl         = '0;
        wr2_idx         = occ_reg[0];
        wr2_job         = '{id: item_reg.proc_id, run_time: item_reg.run_time,
                            prio: item_reg.job_priority};
        for (int i = 0; i < LEVELS; i++)
        begin
            occ_next[i]    = occ_reg[i];
            budget_next[i] = budget_reg[i];
        end
        unique case (state_reg)
            mfq_pkg::ST_DECIDE:
            begin
                cnt_next = '0;
                lvl_next = found_lvl;
                if (!item_reg.action)
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        res_next = '{outcome: mfq_pkg::OC_ADDED, served_level: 2'd0,
                                     served_id: item_reg.proc_id,
                                     remaining_time: item_reg.run_time};
                        if (occ_reg[0] >= OCC_W'(LEVEL_CAPACITY))
                        begin
                            res_next.outcome = mfq_pkg::OC_DROPPED;
                        end
                        else
                        begin
                            wr2_en      = 1'b1;
                            occ_next[0] = occ_reg[0] + OCC_W'(1);
                        end
                    end
                end
                else if (!found && out_free)
                begin
                    emit     = 1'b1;
                    res_next = '{outcome: mfq_pkg::OC_IDLE, served_level: 2'd0,
                                 served_id: 16'd0, remaining_time: 8'd0};
                end
            end
            mfq_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            mfq_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    res_next = '{outcome: commit_code, served_level: 2'(lvl_reg),
                                 served_id: sel_best.id, remaining_time: rem};
                    wr1_en   = 1'b1;
                    wr2_en   = push;
                    wr2_lvl  = dest;
                    wr2_idx  = (dest == lvl_reg) ? occ_reg[dest] - OCC_W'(1)
                                                 : occ_reg[dest];
                    wr2_job  = '{id: sel_best.id, run_time: rem, prio: sel_best.prio};
                    occ_next[lvl_reg] = occ_reg[lvl_reg] - OCC_W'(1);
                    if (push)
                    begin
                        occ_next[dest] = occ_next[dest] + OCC_W'(1);
                    end
                    if (finished || (charged < 0))
                    begin
                        budget_next[lvl_reg] = reload;
                    end
                    else
                    begin
                        budget_next[lvl_reg] = charged;
                    end
                    next_level_next = (lvl_reg == LVL_W'(LEVELS - 1)) ? '0
                                                                      : lvl_reg + LVL_W'(1);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
        res_valid_next = emit || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mfq_pkg::ST_IDLE && job_valid)
        begin
            item_reg <= job;
        end
        if (emit)
        begin
            res_reg <= res_next;
        end
        lvl_reg <= lvl_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mfq_pkg::ST_IDLE;
            next_level_reg <= '0;
            res_valid_reg  <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                occ_reg[i]    <= '0;
                budget_reg[i] <= $signed({1'b0, mfq_pkg::budget_rst(i)});
            end
        end
        else
        begin
            state_reg      <= state_next;
            next_level_reg <= next_level_next;
            res_valid_reg  <= res_valid_next;
            for (int i = 0; i < LEVELS; i++)
            begin
                occ_reg[i]    <= occ_next[i];
                budget_reg[i] <= budget_next[i];
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: src/mfq_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the multilevel feedback scheduler, bound to its top level.
// Depends on mfq_pkg and multilevel_feedback_scheduler_unit.
module mfq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        job_valid,
    input logic                        job_stall,
    input mfq_pkg::in_t                job,
    input logic                        res_valid,
    input logic                        res_stall,
    input mfq_pkg::out_t               res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("Stalled result beat changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_stall |=> job_stall)
        else $error("Job beat accepted while the previous one is in work.");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.outcome == mfq_pkg::OC_IDLE |->
        res.served_id == 16'd0 && res.remaining_time == 8'd0 && res.served_level == 2'd0)
        else $error("Idle result carries a job.");

    a_add_level: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.outcome == mfq_pkg::OC_ADDED || res.outcome == mfq_pkg::OC_DROPPED)
        |-> res.served_level == 2'd0)
        else $error("Added job reported outside level one.");

    a_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.outcome == mfq_pkg::OC_FINISHED |-> res.remaining_time == 8'd0)
        else $error("Finished job reports work left.");

endmodule

bind multilevel_feedback_scheduler_unit mfq_checker u_mfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
